### hdl/lusd_pkg.sv
// ---------------------------------------------------------------------------
// lusd_pkg
// Types, constants and decode helpers shared by the UTF-8 decoder modules.
// ---------------------------------------------------------------------------
package lusd_pkg;

    localparam int CP_W = 21;

    localparam logic [CP_W-1:0] QMARK = CP_W'(63);

    // Lead byte classification: bad lead, or number of continuation bytes.
    typedef struct packed {
        logic       bad;
        logic [1:0] need;
    } lead_t;

    // One packet per input item that produces results: count and code points.
    typedef struct packed {
        logic [1:0]                cnt;
        logic [2:0][CP_W-1:0]      cp;
    } packet_t;

    function automatic lead_t classify(input logic [7:0] b);
        lead_t r;
        r.bad  = 1'b0;
        r.need = 2'd0;
        if (b[7] == 1'b0)
        begin
            r.need = 2'd0;
        end
        else if ((b & 8'hE0) == 8'hC0)
        begin
            r.need = 2'd1;
        end
        else if ((b & 8'hF0) == 8'hE0)
        begin
            r.need = 2'd2;
        end
        else if ((b & 8'hF8) == 8'hF0)
        begin
            r.need = 2'd3;
        end
        else
        begin
            r.bad = 1'b1;
        end
        return r;
    endfunction

    // A byte decoded as a lead with nothing after it.
    function automatic logic [CP_W-1:0] single_cp(input logic [7:0] b);
        return b[7] ? QMARK : {13'd0, b};
    endfunction

endpackage

### hdl/lenient_utf8_stream_decoder.sv
// ---------------------------------------------------------------------------
// lenient_utf8_stream_decoder
// Byte-in, code-point-out UTF-8 decoder without continuation checks.
// ---------------------------------------------------------------------------
// One byte is accepted per cycle while full is low; the front part decodes it
// in that same cycle and posts a packet of up to three code points into a
// QUEUE_DEPTH-entry queue. Results leave one per cycle while pop is high. A
// truncated sequence at string end can release three items from one byte;
// the queue absorbs that burst and full rises only once it is filled. Bytes
// that only extend an unfinished sequence produce nothing. run_last marks
// the final item caused by a byte.
module lenient_utf8_stream_decoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [7:0]                text_byte,
    input  logic                      string_end,
    input  logic                      push,
    output logic                      full,
    output logic [lusd_pkg::CP_W-1:0] code_point,
    output logic                      run_last,
    output logic                      empty,
    input  logic                      pop
);
    import lusd_pkg::*;

    packet_t q_wr_data;
    packet_t q_rd_data;
    logic    q_push;
    logic    q_pop;
    logic    q_full;
    logic    q_empty;

    lusd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_byte  (text_byte),
        .string_end (string_end),
        .push       (push),
        .full       (full),
        .q_push     (q_push),
        .q_data     (q_wr_data),
        .q_full     (q_full)
    );

    lusd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wr_data),
        .rd_en   (q_pop),
        .rd_data (q_rd_data),
        .full    (q_full),
        .empty   (q_empty)
    );

    lusd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (q_rd_data),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .code_point (code_point),
        .run_last   (run_last),
        .empty      (empty),
        .pop        (pop)
    );

endmodule

### hdl/lusd_front.sv
// ---------------------------------------------------------------------------
// lusd_front
// Accepts bytes, holds an unfinished sequence and turns each byte into a
// packet of zero to three code points.
// ---------------------------------------------------------------------------
module lusd_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [7:0]        text_byte,
    input  logic              string_end,
    input  logic              push,
    output logic              full,
    output logic              q_push,
    output lusd_pkg::packet_t q_data,
    input  logic              q_full
);
    import lusd_pkg::*;

    logic [1:0]      cnt_reg;
    logic [1:0]      cnt_next;
    logic [7:0]      held_reg [3];
    logic [7:0]      held_next [3];
    logic [7:0]      lead;
    logic [7:0]      b1;
    logic [7:0]      b2;
    lead_t           lc;
    lead_t           h1c;
    logic [CP_W-1:0] cp_full;
    packet_t         pkt;
    logic            accept;

    assign full   = q_full;
    assign accept = push && !q_full;

    always_comb
    begin
        lead = (cnt_reg == 2'd0) ? text_byte : held_reg[0];
        lc   = classify(lead);
        b1   = (cnt_reg >= 2'd2) ? held_reg[1] : text_byte;
        b2   = (cnt_reg == 2'd3) ? held_reg[2] : text_byte;
        h1c  = classify(held_reg[1]);

        unique case (lc.need)
            2'd0:    cp_full = {13'd0, lead};
            2'd1:    cp_full = {10'd0, lead[4:0], b1[5:0]};
            2'd2:    cp_full = {5'd0, lead[3:0], b1[5:0], b2[5:0]};
            default: cp_full = {lead[2:0], b1[5:0], b2[5:0], text_byte[5:0]};
        endcase

        pkt       = '0;
        cnt_next  = cnt_reg;
        held_next = held_reg;

        if (lc.bad)
        begin
            pkt.cnt   = 2'd1;
            pkt.cp[0] = QMARK;
            cnt_next  = 2'd0;
        end
        else if (lc.need == cnt_reg)
        begin
            pkt.cnt   = 2'd1;
            pkt.cp[0] = cp_full;
            cnt_next  = 2'd0;
        end
        else if (!string_end)
        begin
            held_next[cnt_reg] = text_byte;
            cnt_next           = cnt_reg + 2'd1;
        end
        else
        begin
            // truncated at string end: lead gives '?', the rest re-decoded as leads
            pkt.cp[0] = QMARK;
            cnt_next  = 2'd0;
            case (cnt_reg)
                2'd0:
                begin
                    pkt.cnt = 2'd1;
                end
                2'd1:
                begin
                    pkt.cnt   = 2'd2;
                    pkt.cp[1] = single_cp(text_byte);
                end
                default:
                begin
                    if (!h1c.bad && h1c.need == 2'd1)
                    begin
                        pkt.cnt   = 2'd2;
                        pkt.cp[1] = {10'd0, held_reg[1][4:0], text_byte[5:0]};
                    end
                    else
                    begin
                        pkt.cnt   = 2'd3;
                        pkt.cp[1] = (!h1c.bad && h1c.need == 2'd0) ?
                                    {13'd0, held_reg[1]} : QMARK;
                        pkt.cp[2] = single_cp(text_byte);
                    end
                end
            endcase
        end
    end

    assign q_push = accept && (pkt.cnt != 2'd0);
    assign q_data = pkt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else if (accept)
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            held_reg <= held_next;
        end
    end

endmodule

### hdl/lusd_queue.sv
// ---------------------------------------------------------------------------
// lusd_queue
// Small packet FIFO between the front and back parts.
// ---------------------------------------------------------------------------
module lusd_queue #(
    parameter int DEPTH = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  lusd_pkg::packet_t wr_data,
    input  logic              rd_en,
    output lusd_pkg::packet_t rd_data,
    output logic              full,
    output logic              empty
);
    import lusd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    packet_t            mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_wr;
    logic               do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### hdl/lusd_back.sv
// ---------------------------------------------------------------------------
// lusd_back
// Unpacks the head packet into single code points, one per pop.
// ---------------------------------------------------------------------------
module lusd_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  lusd_pkg::packet_t         head,
    input  logic                      q_empty,
    output logic                      q_pop,
    output logic [lusd_pkg::CP_W-1:0] code_point,
    output logic                      run_last,
    output logic                      empty,
    input  logic                      pop
);
    import lusd_pkg::*;

    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic       take;

    assign empty      = q_empty;
    assign code_point = head.cp[idx_reg];
    assign run_last   = (idx_reg == head.cnt - 2'd1);
    assign take       = pop && !q_empty;
    assign q_pop      = take && run_last;

    always_comb
    begin
        idx_next = idx_reg;
        if (take)
        begin
            idx_next = run_last ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= 2'd0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

endmodule

### dv/tb_lenient_utf8_stream_decoder.sv
// ---------------------------------------------------------------------------
// tb_lenient_utf8_stream_decoder
// Self-checking bench for the lenient UTF-8 decoder. A driver feeds bytes
// from a queue filled with directed cases, then with random bytes and strings.
// A monitor predicts the code points of each accepted item and checks every
// popped result in order. Both sides idle at random, and the receiver
// holds off once for a long stretch so that full gets exercised.
// ---------------------------------------------------------------------------
module tb_lenient_utf8_stream_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    import lusd_pkg::*;

    localparam int N_ITEMS      = 330;
    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AFTER   = 60;
    localparam int DRAIN_CYCLES = 20;

    typedef enum int {RX_STREAM, RX_HALF, RX_SPARSE, RX_MOSTLY} rx_mode_t;

    typedef struct {
        logic [7:0] b;
        logic       fin;
    } byte_item_t;

    typedef struct {
        logic [CP_W-1:0] cp;
        logic            last;
    } cp_item_t;

    logic            clk        = 1'b0;
    logic            rst_n      = 1'b0;
    logic [7:0]      text_byte  = 8'h00;
    logic            string_end = 1'b0;
    logic            push       = 1'b0;
    logic            pop        = 1'b0;
    logic            full;
    logic            empty;
    logic            run_last;
    logic [CP_W-1:0] code_point;

    byte_item_t pending_bytes[$];
    cp_item_t   cp_expect[$];

    // decoder state as seen by the predictor
    logic [7:0] held_q [0:2];
    int         held_n = 0;

    int       n_errors    = 0;
    int       n_sent      = 0;
    int       n_checked   = 0;
    int       n_total     = 0;
    int       burst_left  = 8;
    int       gap_left    = 0;
    int       hold_left   = 0;
    bit       hold_done   = 1'b0;
    rx_mode_t rx_mode     = RX_STREAM;
    int       mode_age    = 40;
    int       idle_cycles = 0;

    lenient_utf8_stream_decoder dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_byte  (text_byte),
        .string_end (string_end),
        .push       (push),
        .full       (full),
        .code_point (code_point),
        .run_last   (run_last),
        .empty      (empty),
        .pop        (pop)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Decode one accepted byte against the held bytes, queue its code points.
    function automatic void decode_byte(input logic [7:0] b, input logic fin);
        logic [7:0]      bytes_w [0:3];
        logic [CP_W-1:0] res [0:3];
        logic [CP_W-1:0] cp;
        logic [7:0]      c;
        logic            bad;
        int              len;
        int              pos;
        int              need;
        int              n;
        int              i;
        cp_item_t        r;
        len = held_n;
        for (i = 0; i < len; i++)
            bytes_w[i] = held_q[i];
        bytes_w[len] = b;
        len++;
        pos = 0;
        n = 0;
        while (pos < len)
        begin
            c = bytes_w[pos];
            bad = 1'b0;
            need = 0;
            cp = '0;
            casez (c)
                8'b0???????: cp = CP_W'(c);
                8'b110?????:
                begin
                    need = 1;
                    cp = CP_W'(c[4:0]);
                end
                8'b1110????:
                begin
                    need = 2;
                    cp = CP_W'(c[3:0]);
                end
                8'b11110???:
                begin
                    need = 3;
                    cp = CP_W'(c[2:0]);
                end
                default: bad = 1'b1;
            endcase
            if (bad)
            begin
                res[n] = QMARK;
                n++;
                pos++;
            end
            else if (pos + need < len)
            begin
                // continuation bytes are taken as they are
                for (i = 1; i <= need; i++)
                    cp = {cp[CP_W-7:0], bytes_w[pos+i][5:0]};
                res[n] = cp;
                n++;
                pos += need + 1;
            end
            else if (fin)
            begin
                // truncated lead; the bytes after it are tried as leads
                res[n] = QMARK;
                n++;
                pos++;
            end
            else
            begin
                break;
            end
        end
        held_n = len - pos;
        for (i = 0; i < held_n; i++)
            held_q[i] = bytes_w[pos+i];
        for (i = 0; i < n; i++)
        begin
            r.cp = res[i];
            r.last = (i == n - 1);
            cp_expect.push_back(r);
        end
    endfunction

    task automatic add_item(input logic [7:0] b, input logic fin);
        byte_item_t it;
        it.b = b;
        it.fin = fin;
        pending_bytes.push_back(it);
    endtask

    function automatic logic [7:0] rand_cont();
        return ($urandom_range(0, 4) == 0) ? 8'($urandom) : {2'b10, 6'($urandom)};
    endfunction

    // A string of random characters, the last one sometimes cut short.
    task automatic add_string(input int n_chars);
        logic [7:0] seq[$];
        logic [7:0] lead;
        int         k;
        int         j;
        int         kind;
        int         need;
        int         cut;
        for (k = 0; k < n_chars; k++)
        begin
            kind = $urandom_range(0, 99);
            need = 0;
            if (kind < 35)
            begin
                lead = 8'($urandom_range(0, 127));
            end
            else if (kind < 55)
            begin
                lead = {3'b110, 5'($urandom)};
                need = 1;
            end
            else if (kind < 75)
            begin
                lead = {4'b1110, 4'($urandom)};
                need = 2;
            end
            else if (kind < 90)
            begin
                lead = {5'b11110, 3'($urandom)};
                need = 3;
            end
            else if ($urandom_range(0, 1) == 0)
            begin
                lead = {2'b10, 6'($urandom)};
            end
            else
            begin
                lead = {5'b11111, 3'($urandom)};
            end
            seq.push_back(lead);
            for (j = 0; j < need; j++)
                seq.push_back(rand_cont());
            if (k == n_chars - 1 && need > 0 && $urandom_range(0, 3) == 0)
            begin
                cut = $urandom_range(1, need);
                for (j = 0; j < cut; j++)
                    void'(seq.pop_back());
            end
        end
        foreach (seq[i])
            add_item(seq[i], i == seq.size() - 1);
    endtask

    initial
    begin
        // directed: plain ASCII extremes, each sequence length, bad leads,
        // truncation at string end
        add_item(8'h00, 1'b1);
        add_item(8'h7F, 1'b1);
        add_item(8'hC2, 1'b0);
        add_item(8'hA9, 1'b1);
        add_item(8'hE2, 1'b0);
        add_item(8'h82, 1'b0);
        add_item(8'hAC, 1'b1);
        add_item(8'hF7, 1'b0);
        add_item(8'hBF, 1'b0);
        add_item(8'hBF, 1'b0);
        add_item(8'hBF, 1'b1);
        add_item(8'h80, 1'b1);
        add_item(8'hFF, 1'b0);
        add_item(8'hF8, 1'b1);
        add_item(8'hF0, 1'b0);
        add_item(8'h41, 1'b0);
        add_item(8'h42, 1'b1);
        add_item(8'hE0, 1'b1);
        add_item(8'hF0, 1'b0);
        add_item(8'hE0, 1'b0);
        add_item(8'hC3, 1'b1);
        add_item(8'hC0, 1'b0);
        add_item(8'h00, 1'b1);
        while (pending_bytes.size() < N_ITEMS)
        begin
            if ($urandom_range(0, 99) < 15)
                add_item(8'($urandom), $urandom_range(0, 3) == 0);
            else
                add_string($urandom_range(1, 6));
        end
        n_total = pending_bytes.size();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (n_sent < n_total)
            @(negedge clk);
        while (cp_expect.size() > 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (n_errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Sender: bursts of random length separated by random gaps.
    always @(posedge clk)
    begin
        byte_item_t nxt;
        if (rst_n)
        begin
            if (!push || !full)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    push <= 1'b0;
                end
                else if (pending_bytes.size() > 0)
                begin
                    nxt = pending_bytes.pop_front();
                    text_byte <= nxt.b;
                    string_end <= nxt.fin;
                    push <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                    end
                end
                else
                begin
                    push <= 1'b0;
                end
            end
        end
    end

    // Monitor: predict on each accepted item, check each popped result,
    // and steer pop.
    always @(posedge clk)
    begin
        cp_item_t want;
        if (rst_n)
        begin
            if (push && !full)
            begin
                decode_byte(text_byte, string_end);
                n_sent++;
            end
            if (pop && !empty)
            begin
                n_checked++;
                if (cp_expect.size() == 0)
                begin
                    $display("%0t: unexpected item, code_point expected none got %0h",
                             $time, code_point);
                    n_errors++;
                end
                else
                begin
                    want = cp_expect.pop_front();
                    if (code_point !== want.cp)
                    begin
                        $display("%0t: code_point expected %0h got %0h",
                                 $time, want.cp, code_point);
                        n_errors++;
                    end
                    if (run_last !== want.last)
                    begin
                        $display("%0t: run_last expected %0b got %0b",
                                 $time, want.last, run_last);
                        n_errors++;
                    end
                end
            end

            // one long hold-off so the queue fills and full rises
            if (!hold_done && n_checked >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (mode_age == 0)
            begin
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                mode_age = $urandom_range(20, 80);
            end
            else
            begin
                mode_age--;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
            begin
                case (rx_mode)
                    RX_STREAM: pop <= 1'b1;
                    RX_HALF:   pop <= 1'($urandom_range(0, 1));
                    RX_SPARSE: pop <= ($urandom_range(0, 3) == 0);
                    default:   pop <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // Watchdog: ends the run when nothing moves for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
                if (idle_cycles >= STALL_LIMIT)
                begin
                    $display("FAILURE");
                    $finish;
                end
            end
        end
    end

endmodule
